// ===== src/rch_pkg.sv =====
// Shared types and constants of the RGB channel histogram.
package rch_pkg;

  // Width of every sample, bin index and bin number field at the ports.
  localparam int unsigned FIELD_W = 16;

  // Low bits of a sample that select a bin in 8-bit mode.
  localparam int unsigned NARROW_BITS = 8;

  // Depth of the queue between the front and back parts.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = 1;
  localparam int unsigned QUEUE_CNT_W = 2;

  // Item kinds.
  typedef enum logic {
    KIND_PIXEL = 1'b0,
    KIND_READ  = 1'b1
  } kind_t;

  // One classified item. For a read all three bins hold the read index.
  typedef struct packed {
    kind_t               kind;
    logic [FIELD_W-1:0]  red_bin;
    logic [FIELD_W-1:0]  green_bin;
    logic [FIELD_W-1:0]  blue_bin;
  } hist_item_t;

endpackage

// ===== src/rch_front.sv =====
// Front part: accepts input beats, holds the mode register and works out bin indexes.
module rch_front #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic                        cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_kind,
  input  logic [rch_pkg::FIELD_W-1:0] in_red_sample,
  input  logic [rch_pkg::FIELD_W-1:0] in_green_sample,
  input  logic [rch_pkg::FIELD_W-1:0] in_blue_sample,
  input  logic [rch_pkg::FIELD_W-1:0] in_bin_index,
  input  logic                        q_full,
  input  logic                        clearing,
  output logic                        q_push,
  output rch_pkg::hist_item_t         q_item
);

  localparam logic [rch_pkg::FIELD_W-1:0] BIN_MASK =
    rch_pkg::FIELD_W'((32'd1 << SAMPLE_BITS) - 32'd1);
  localparam logic [rch_pkg::FIELD_W-1:0] NARROW_MASK =
    rch_pkg::FIELD_W'((32'd1 << rch_pkg::NARROW_BITS) - 32'd1);

  logic sample_wide_r;
  logic [rch_pkg::FIELD_W-1:0] sample_mask;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_wide_r <= 1'b1;
    end else if (cfg_wr_en) begin
      sample_wide_r <= cfg_wr_data;
    end
  end

  assign sample_mask = sample_wide_r ? BIN_MASK : (NARROW_MASK & BIN_MASK);
  assign in_ready    = !q_full && !clearing;
  assign q_push      = in_valid && in_ready;

  always_comb begin
    q_item.kind = rch_pkg::kind_t'(in_kind);
    unique case (rch_pkg::kind_t'(in_kind))
      rch_pkg::KIND_READ: begin
        // The read index is reduced to the store depth, not by the mode.
        q_item.red_bin   = in_bin_index & BIN_MASK;
        q_item.green_bin = in_bin_index & BIN_MASK;
        q_item.blue_bin  = in_bin_index & BIN_MASK;
      end
      default: begin
        q_item.red_bin   = in_red_sample & sample_mask;
        q_item.green_bin = in_green_sample & sample_mask;
        q_item.blue_bin  = in_blue_sample & sample_mask;
      end
    endcase
  end

endmodule

// ===== src/rch_queue.sv =====
// Short queue of classified items between the front and back parts.
module rch_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  rch_pkg::hist_item_t push_item,
  output logic                full,
  input  logic                pop,
  output logic                valid,
  output rch_pkg::hist_item_t pop_item
);

  rch_pkg::hist_item_t                 entry_r [rch_pkg::QUEUE_DEPTH];
  logic [rch_pkg::QUEUE_PTR_W-1:0]     wr_ptr_r;
  logic [rch_pkg::QUEUE_PTR_W-1:0]     rd_ptr_r;
  logic [rch_pkg::QUEUE_CNT_W-1:0]     count_r;

  assign full     = (count_r == rch_pkg::QUEUE_CNT_W'(rch_pkg::QUEUE_DEPTH));
  assign valid    = (count_r != '0);
  assign pop_item = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + rch_pkg::QUEUE_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + rch_pkg::QUEUE_PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + rch_pkg::QUEUE_CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - rch_pkg::QUEUE_CNT_W'(1);
      end
    end
  end

endmodule

// ===== src/rch_back.sv =====
// Back part: clears the bin memories after reset and runs each item's read-modify-write.
module rch_back #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned COUNT_BITS  = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  input  rch_pkg::hist_item_t         q_item,
  output logic                        q_pop,
  output logic                        clearing,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [rch_pkg::FIELD_W-1:0] out_bin_number,
  output logic [COUNT_BITS-1:0]       out_red_count,
  output logic [COUNT_BITS-1:0]       out_green_count,
  output logic [COUNT_BITS-1:0]       out_blue_count
);

  localparam int unsigned BIN_COUNT = 1 << SAMPLE_BITS;

  typedef enum logic [2:0] {
    ST_CLEAR  = 3'b001,
    ST_FETCH  = 3'b010,
    ST_UPDATE = 3'b100
  } back_state_t;

  back_state_t state_r, state_nxt;

  logic [COUNT_BITS-1:0] red_mem   [BIN_COUNT];
  logic [COUNT_BITS-1:0] green_mem [BIN_COUNT];
  logic [COUNT_BITS-1:0] blue_mem  [BIN_COUNT];

  logic [COUNT_BITS-1:0]  red_rd_r, green_rd_r, blue_rd_r;
  logic [SAMPLE_BITS-1:0] clr_cnt_r;
  rch_pkg::hist_item_t    item_r;

  logic                   can_go, upd_go, load_out, mem_we, zero_wr;
  logic [SAMPLE_BITS-1:0] red_waddr, green_waddr, blue_waddr;
  logic [COUNT_BITS-1:0]  red_wdata, green_wdata, blue_wdata;

  logic                        out_valid_r;
  logic [rch_pkg::FIELD_W-1:0] out_bin_number_r;
  logic [COUNT_BITS-1:0]       out_red_count_r, out_green_count_r, out_blue_count_r;

  assign clearing = (state_r == ST_CLEAR);
  assign q_pop    = (state_r == ST_FETCH) && q_valid;
  // A read waits in the update step until the output register is free.
  assign can_go   = (item_r.kind == rch_pkg::KIND_PIXEL) || !out_valid_r || out_ready;
  assign upd_go   = (state_r == ST_UPDATE) && can_go;
  assign load_out = upd_go && (item_r.kind == rch_pkg::KIND_READ);
  assign mem_we   = clearing || upd_go;
  assign zero_wr  = clearing || (item_r.kind == rch_pkg::KIND_READ);

  always_comb begin
    if (clearing) begin
      red_waddr   = clr_cnt_r;
      green_waddr = clr_cnt_r;
      blue_waddr  = clr_cnt_r;
    end else begin
      red_waddr   = item_r.red_bin[SAMPLE_BITS-1:0];
      green_waddr = item_r.green_bin[SAMPLE_BITS-1:0];
      blue_waddr  = item_r.blue_bin[SAMPLE_BITS-1:0];
    end
    red_wdata   = zero_wr ? '0 : red_rd_r + COUNT_BITS'(1);
    green_wdata = zero_wr ? '0 : green_rd_r + COUNT_BITS'(1);
    blue_wdata  = zero_wr ? '0 : blue_rd_r + COUNT_BITS'(1);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:  if (&clr_cnt_r) state_nxt = ST_FETCH;
      ST_FETCH:  if (q_valid) state_nxt = ST_UPDATE;
      ST_UPDATE: if (can_go) state_nxt = ST_FETCH;
      default:   state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (clearing) begin
        clr_cnt_r <= clr_cnt_r + SAMPLE_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      red_mem[red_waddr]     <= red_wdata;
      green_mem[green_waddr] <= green_wdata;
      blue_mem[blue_waddr]   <= blue_wdata;
    end
    if (q_pop) begin
      red_rd_r   <= red_mem[q_item.red_bin[SAMPLE_BITS-1:0]];
      green_rd_r <= green_mem[q_item.green_bin[SAMPLE_BITS-1:0]];
      blue_rd_r  <= blue_mem[q_item.blue_bin[SAMPLE_BITS-1:0]];
      item_r     <= q_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_bin_number_r  <= item_r.red_bin;
      out_red_count_r   <= red_rd_r;
      out_green_count_r <= green_rd_r;
      out_blue_count_r  <= blue_rd_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_bin_number  = out_bin_number_r;
  assign out_red_count   = out_red_count_r;
  assign out_green_count = out_green_count_r;
  assign out_blue_count  = out_blue_count_r;

`ifndef SYNTH
  a_no_pop_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !q_pop)
    else $error("queue popped during the clearing pass");

  a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> (!out_valid_r || out_ready))
    else $error("output register overwritten before it was taken");

  a_no_write_in_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FETCH) |-> !mem_we)
    else $error("bin memory written outside clear or update");

  a_update_follows_pop: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r == ST_UPDATE))
    else $error("popped item did not enter the update step");

  a_update_returns: assert property (@(posedge clk) disable iff (!rst_n)
    upd_go |=> (state_r == ST_FETCH))
    else $error("update step did not return to fetch");
`endif

endmodule

// ===== src/rgb_channel_histogram.sv =====
// Top level of the per-channel RGB histogram: front, queue and back parts.
//
//   channel  direction  handshake            payload
//   in       input      in_valid/in_ready    kind, red/green/blue sample, bin index
//   out      output     out_valid/out_ready  bin number, red/green/blue count
//   cfg      input      cfg_wr_en            sample_wide mode bit (cfg_wr_data)
//
// The back part takes every item, pixel or read, through a fetch step that reads
// the three bin memories and an update step that writes the updated counts back,
// so it takes no new item from the queue until the last one is written back.
// After reset the back part clears all 2^SAMPLE_BITS bins, one per cycle (65536
// bins at the default), and in_ready stays low until that pass is done.
// A two-beat queue parts the front from the back, and a read beat waits in the
// back part only while the output register still holds an untaken beat.
module rgb_channel_histogram #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned COUNT_BITS  = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic                        cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_kind,
  input  logic [rch_pkg::FIELD_W-1:0] in_red_sample,
  input  logic [rch_pkg::FIELD_W-1:0] in_green_sample,
  input  logic [rch_pkg::FIELD_W-1:0] in_blue_sample,
  input  logic [rch_pkg::FIELD_W-1:0] in_bin_index,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [rch_pkg::FIELD_W-1:0] out_bin_number,
  output logic [COUNT_BITS-1:0]       out_red_count,
  output logic [COUNT_BITS-1:0]       out_green_count,
  output logic [COUNT_BITS-1:0]       out_blue_count
);

  // Classified beats travel from the front into the queue, and from the
  // queue into the back part, as one item struct each.
  logic                q_push, q_full, q_pop, q_valid, clearing;
  rch_pkg::hist_item_t push_item, pop_item;

  rch_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_red_sample   (in_red_sample),
    .in_green_sample (in_green_sample),
    .in_blue_sample  (in_blue_sample),
    .in_bin_index    (in_bin_index),
    .q_full          (q_full),
    .clearing        (clearing),
    .q_push          (q_push),
    .q_item          (push_item)
  );

  rch_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_item  (pop_item)
  );

  rch_back #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_item          (pop_item),
    .q_pop           (q_pop),
    .clearing        (clearing),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_bin_number  (out_bin_number),
    .out_red_count   (out_red_count),
    .out_green_count (out_green_count),
    .out_blue_count  (out_blue_count)
  );

endmodule
